// File: rtl/etb_pkg.sv
// ----------------------------------------------------------------------------
// etb_pkg
// Shared types for the extended timebase: the operation codes of a request.
// ----------------------------------------------------------------------------
`default_nettype none

package etb_pkg;

   // Request kinds, carried in req_tuser. The fourth code is unused and is
   // treated as a no-op.
   typedef enum logic [1:0] {
      OP_TICK        = 2'd0,
      OP_READ        = 2'd1,
      OP_SET_COMPARE = 2'd2
   } opcode_type;

endpackage

`default_nettype wire

// File: rtl/extended_timebase_with_compare.sv
// ----------------------------------------------------------------------------
// extended_timebase_with_compare
// Extends a reloading down-counter into a wide elapsed-tick count and
// schedules one compare event against it.
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                       tuser
//  req      in   target_time[TIME_BITS-1:0], zero pad     opcode[1:0]
//  rsp      out  now_ticks[TIME_BITS-1:0], event_fire,    -
//                zero pad
//
//  One word per cycle sustained while rsp_tready stays high; a word passes
//  the input register, then the result register, before rsp_tvalid rises.
//  The rate is set by the state update: counter, snapshot add, total add and
//  compare all close combinationally between input and result registers.
//  Reset: synchronous, active high; counter idle at zero, compare idle.
//  Stalls: the result register holds while rsp_tready is low; the input
//  register still takes one more word, then req_tready drops.
//
`default_nettype none

module extended_timebase_with_compare #(
   parameter int COUNTER_BITS = 24,
   parameter int TIME_BITS    = 48
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // target_time[TIME_BITS-1:0], zero pad
   input  wire logic [((TIME_BITS+7)/8)*8-1:0]       req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]                           req_tuser,

   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // now_ticks[TIME_BITS-1:0], event_fire, zero pad
   output logic      [((TIME_BITS+8)/8)*8-1:0]       rsp_tdata
);

   // input register
   logic                 req_valid_ff;
   logic [1:0]           req_opcode_ff;
   logic [TIME_BITS-1:0] req_target_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [TIME_BITS-1:0] rsp_now_ff;
   logic                 rsp_fire_ff;

   logic                 step;
   logic [TIME_BITS-1:0] now_ticks;
   logic                 event_fire;

   // a held word moves on whenever the result slot is free or draining
   assign step       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_opcode_ff <= req_tuser;
         req_target_ff <= req_tdata[TIME_BITS-1:0];
      end
   end

   etb_timebase #(
      .COUNTER_BITS (COUNTER_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_timebase (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .opcode     (etb_pkg::opcode_type'(req_opcode_ff)),
      .target     (req_target_ff),
      .now_ticks  (now_ticks),
      .event_fire (event_fire)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_now_ff  <= now_ticks;
         rsp_fire_ff <= event_fire;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                  = '0;
      rsp_tdata[TIME_BITS-1:0]   = rsp_now_ff;
      rsp_tdata[TIME_BITS]       = rsp_fire_ff;
   end

endmodule

`default_nettype wire

// File: rtl/etb_timebase.sv
// ----------------------------------------------------------------------------
// etb_timebase
// Timebase state and its combinational update: down-counter with reload,
// wrap-aware accumulation into the elapsed total, and compare handling.
// ----------------------------------------------------------------------------
`default_nettype none

module etb_timebase #(
   parameter int COUNTER_BITS = 24,
   parameter int TIME_BITS    = 48
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   step,      // apply one word this cycle
   input  wire etb_pkg::opcode_type    opcode,
   input  wire logic [TIME_BITS-1:0]   target,
   output logic      [TIME_BITS-1:0]   now_ticks, // total after this word
   output logic                        event_fire
);

   localparam logic [COUNTER_BITS-1:0] CNT_MAX  = '1;
   localparam logic [TIME_BITS-1:0]    TIME_MAX = '1;

   logic [COUNTER_BITS-1:0] down_count_ff, down_count_in;
   logic [COUNTER_BITS-1:0] reload_ff, reload_in;
   logic                    wrap_ff, wrap_in;
   logic [COUNTER_BITS-1:0] snapshot_ff, snapshot_in;
   logic [TIME_BITS-1:0]    total_ff, total_in;
   logic [TIME_BITS-1:0]    next_event_ff, next_event_in;

   logic [COUNTER_BITS:0]   spent;
   logic [TIME_BITS-1:0]    read_total;
   logic [TIME_BITS-1:0]    wrap_total;
   logic [COUNTER_BITS-1:0] dec_count;
   logic [TIME_BITS-1:0]    cmp_now;
   logic [TIME_BITS-1:0]    cmp_target;
   logic                    cmp_passed;
   logic [TIME_BITS-1:0]    distance;
   logic [COUNTER_BITS-1:0] load_value;
   logic                    fire;

   // Progress since the last snapshot, one bit wider than the counter.
   always_comb begin
      if (wrap_ff || (down_count_ff >= snapshot_ff)) begin
         if (down_count_ff != '0) begin
            spent = {1'b0, snapshot_ff} + {1'b0, reload_ff} - {1'b0, down_count_ff};
         end else begin
            spent = {1'b0, snapshot_ff};
         end
      end else begin
         spent = {1'b0, snapshot_ff} - {1'b0, down_count_ff};
      end
   end

   assign read_total = total_ff + TIME_BITS'(spent);
   // On the 1-to-0 step the counter reaches zero: the progress is simply
   // the snapshot.
   assign wrap_total = total_ff + TIME_BITS'(snapshot_ff);
   assign dec_count  = down_count_ff - 1'b1;

   // One compare/subtract shared by the handler and set-compare.
   assign cmp_now    = (opcode == etb_pkg::OP_TICK) ? wrap_total : read_total;
   assign cmp_target = (opcode == etb_pkg::OP_TICK) ? next_event_ff : target;
   assign cmp_passed = cmp_now >= cmp_target;
   assign distance   = cmp_target - cmp_now;
   assign load_value = (cmp_target == TIME_MAX) ? CNT_MAX :
                       (distance >= TIME_BITS'(CNT_MAX)) ? CNT_MAX :
                       distance[COUNTER_BITS-1:0];

   always_comb begin
      down_count_in = down_count_ff;
      reload_in     = reload_ff;
      wrap_in       = wrap_ff;
      snapshot_in   = snapshot_ff;
      total_in      = total_ff;
      next_event_in = next_event_ff;
      fire          = 1'b0;

      case (opcode)
         etb_pkg::OP_TICK: begin
            if (down_count_ff == '0) begin
               down_count_in = reload_ff;
            end else begin
               down_count_in = dec_count;
               if (dec_count == '0) begin
                  // handler: read, then fire or re-arm with the same target
                  total_in    = wrap_total;
                  snapshot_in = '0;
                  wrap_in     = 1'b0;
                  if (cmp_passed) begin
                     fire = 1'b1;
                  end else begin
                     snapshot_in   = load_value;
                     reload_in     = load_value - 1'b1;
                     down_count_in = '0;
                  end
               end
            end
         end
         etb_pkg::OP_READ: begin
            wrap_in     = 1'b0;
            snapshot_in = down_count_ff;
            total_in    = read_total;
         end
         etb_pkg::OP_SET_COMPARE: begin
            wrap_in       = 1'b0;
            snapshot_in   = down_count_ff;
            total_in      = read_total;
            next_event_in = target;
            if (target != TIME_MAX && cmp_passed) begin
               fire = 1'b1;
            end else begin
               snapshot_in   = load_value;
               reload_in     = load_value - 1'b1;
               down_count_in = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_count_ff <= '0;
         reload_ff     <= CNT_MAX - 1'b1;
         wrap_ff       <= 1'b0;
         snapshot_ff   <= CNT_MAX;
         total_ff      <= '0;
         next_event_ff <= TIME_MAX;
      end else if (step) begin
         down_count_ff <= down_count_in;
         reload_ff     <= reload_in;
         wrap_ff       <= wrap_in;
         snapshot_ff   <= snapshot_in;
         total_ff      <= total_in;
         next_event_ff <= next_event_in;
      end
   end

   assign now_ticks  = total_in;
   assign event_fire = fire;

endmodule

`default_nettype wire

// File: tb/extended_timebase_with_compare_test.sv
// ----------------------------------------------------------------------------
// extended_timebase_with_compare_test
// Self-checking bench for the extended timebase. It drives tick, read,
// set-compare and unused-opcode words with random stalls on both channels.
// It keeps its own copy of the counter, snapshot, total and compare target,
// and checks every result word against that copy or a hand-typed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module extended_timebase_with_compare_test;

   localparam int CNT_W       = 24;
   localparam int TIME_W      = 48;
   localparam int IDLE_PCT    = 11;     // chance per cycle that a side idles
   localparam int STALL_LIMIT = 1000;   // cycles with no word moving
   localparam int RANDOM_WORDS = 1075;
   localparam int PLAN_LEN    = 28;

   // Fourth opcode: not a member of the package enum, must behave as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
   localparam logic [TIME_W-1:0] TIME_IDLE = '1;   // compare target "none"

   // -------------------------------------------------------------------------
   // Clock, reset and DUT ports; all inputs known from time zero
   // -------------------------------------------------------------------------
   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [TIME_W-1:0]   req_tdata  = '0;     // target_time[47:0]
   logic [1:0]          req_tuser  = 2'd0;   // opcode[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [55:0]         rsp_tdata;           // now_ticks[47:0], event_fire, pad

   always #5 clock = ~clock;

   extended_timebase_with_compare #(
      .COUNTER_BITS (CNT_W),
      .TIME_BITS    (TIME_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // -------------------------------------------------------------------------
   // Timebase state as the bench sees it
   // -------------------------------------------------------------------------
   typedef struct {
      logic [CNT_W-1:0]  down;       // down-counter
      logic [CNT_W-1:0]  reload;     // value loaded when the counter sits at zero
      logic              wrapped;    // set on the 1-to-0 step, cleared by a read
      logic [CNT_W-1:0]  snap;       // counter value at the last read or load
      logic [TIME_W-1:0] total;      // elapsed ticks
      logic [TIME_W-1:0] deadline;   // compare target, all ones when idle
   } timebase_type;

   typedef struct packed {
      logic              fire;
      logic [TIME_W-1:0] now;
   } outcome_type;

   typedef struct packed {
      logic [1:0]        op;
      logic              rel;        // target = current time + tgt
      logic [TIME_W-1:0] tgt;
      logic              typed;      // result below is written out by hand
      logic [TIME_W-1:0] now;
      logic              fire;
   } plan_row_type;

   timebase_type  timebase;
   outcome_type   due_results [$];
   int            mismatches     = 0;
   int            stalled_cycles = 0;
   bit            steady         = 1'b0;   // no idling on either side while set

   // Read: fold counter progress since the last snapshot into the total.
   // Progress is 25 bits wide so a wrap plus the remaining count fits.
   function automatic void fold_progress(inout timebase_type s);
      logic [CNT_W:0] spent;
      if (s.wrapped || s.down >= s.snap) begin
         if (s.down != '0)
            spent = {1'b0, s.snap} + {1'b0, s.reload} - {1'b0, s.down};
         else
            spent = {1'b0, s.snap};
      end else begin
         spent = {1'b0, s.snap} - {1'b0, s.down};
      end
      s.wrapped = 1'b0;
      s.snap    = s.down;
      s.total   = s.total + TIME_W'(spent);
   endfunction

   function automatic void load_count(inout timebase_type s, input logic [CNT_W-1:0] v);
      s.snap    = v;
      s.reload  = v - 1'b1;
      s.down    = '0;
      s.wrapped = 1'b0;
   endfunction

   // Set-compare; returns 1 when the target is already due.
   function automatic logic arm_compare(inout timebase_type s,
                                        input logic [TIME_W-1:0] tgt);
      logic [TIME_W-1:0] remaining;
      logic              fire;
      fire = 1'b0;
      fold_progress(s);
      s.deadline = tgt;
      if (tgt == TIME_IDLE) begin
         load_count(s, CNT_MAX);
      end else if (s.total >= tgt) begin
         fire = 1'b1;                       // passed target: counter untouched
      end else begin
         remaining = tgt - s.total;
         load_count(s, (remaining >= TIME_W'(CNT_MAX)) ? CNT_MAX
                                                       : remaining[CNT_W-1:0]);
      end
      return fire;
   endfunction

   // One request word against the state; returns event_fire.
   function automatic logic apply_word(inout timebase_type s, input logic [1:0] op,
                                       input logic [TIME_W-1:0] tgt);
      logic fire;
      fire = 1'b0;
      case (op)
         etb_pkg::OP_TICK: begin
            if (s.down == '0) begin
               s.down = s.reload;
            end else begin
               s.down = s.down - 1'b1;
               if (s.down == '0) begin
                  // handler: read, then fire or re-arm with the same target
                  s.wrapped = 1'b1;
                  fold_progress(s);
                  if (s.total >= s.deadline)
                     fire = 1'b1;
                  else
                     fire = arm_compare(s, s.deadline);
               end
            end
         end
         etb_pkg::OP_READ:        fold_progress(s);
         etb_pkg::OP_SET_COMPARE: fire = arm_compare(s, tgt);
         default: ;
      endcase
      return fire;
   endfunction

   // Time a set-compare would see, without touching the real state.
   function automatic logic [TIME_W-1:0] now_if_read();
      timebase_type t;
      t = timebase;
      fold_progress(t);
      return t.total;
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatches < 10)
         $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // -------------------------------------------------------------------------
   // Directed words. Only the first rows after reset carry a typed result;
   // relative rows add their tgt to the time the block will see.
   // -------------------------------------------------------------------------
   plan_row_type plan [PLAN_LEN] = '{
      // read right after reset: snapshot starts at counter max
      '{etb_pkg::OP_READ,        1'b0, 48'h0,              1'b1, 48'h00_0000_FF_FFFF, 1'b0},
      '{OP_UNUSED,               1'b0, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h00_0000_FF_FFFF, 1'b0},
      // target zero has passed: fires at once
      '{etb_pkg::OP_SET_COMPARE, 1'b0, 48'h0,              1'b1, 48'h00_0000_FF_FFFF, 1'b1},
      // idle target: counter reloaded to max, no event
      '{etb_pkg::OP_SET_COMPARE, 1'b0, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h00_0000_FF_FFFF, 1'b0},
      '{etb_pkg::OP_READ,        1'b0, 48'h0,              1'b1, 48'h0000_01FF_FFFE, 1'b0},
      // distance one: zero reload, counter parks at zero
      '{etb_pkg::OP_SET_COMPARE, 1'b1, 48'h1,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_READ,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      // short distance: wrap handler runs after a few ticks
      '{etb_pkg::OP_SET_COMPARE, 1'b1, 48'h3,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_READ,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      // target equal to now, then one in the past
      '{etb_pkg::OP_SET_COMPARE, 1'b1, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_SET_COMPARE, 1'b1, 48'hFFFF_FFFF_FFF9, 1'b0, 48'h0, 1'b0},
      // passed target stays stored: every wrap fires again
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      // distance exactly counter max, then beyond it (saturates)
      '{etb_pkg::OP_SET_COMPARE, 1'b1, 48'hFF_FFFF,        1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_SET_COMPARE, 1'b1, 48'h200_0000,       1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_SET_COMPARE, 1'b0, 48'hFFFF_FFFF_FFFE, 1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_SET_COMPARE, 1'b0, 48'h8000_0000_0000, 1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_TICK,        1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0, 1'b0},
      '{OP_UNUSED,               1'b0, 48'h0,              1'b0, 48'h0, 1'b0},
      '{etb_pkg::OP_READ,        1'b0, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0, 1'b0}
   };

   // Offer one word, wait for the handshake, then log what must come back.
   // Valid is never lowered here after an accept, so the next call owns it.
   task automatic send_word(input logic [1:0] op, input logic [TIME_W-1:0] tgt,
                            input logic typed, input outcome_type typed_val);
      outcome_type due;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= tgt;
      do @(posedge clock); while (!req_tready);
      due.fire = apply_word(timebase, op, tgt);
      due.now  = timebase.total;
      due_results.push_back(typed ? typed_val : due);
   endtask

   // Sender holds off until every outstanding result word has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   // Mostly ticks and near targets so the counter wraps often; the rest
   // are reads, far, passed, idle and fully random targets, plus no-op words.
   task automatic random_word();
      logic [63:0]       noise;
      logic [TIME_W-1:0] tgt;
      logic [1:0]        op;
      int                pick;
      noise = {$urandom, $urandom};
      tgt   = noise[TIME_W-1:0];
      pick  = $urandom_range(99);
      if (pick < 58)
         op = etb_pkg::OP_TICK;
      else if (pick < 70)
         op = etb_pkg::OP_READ;
      else if (pick < 73)
         op = OP_UNUSED;
      else begin
         op   = etb_pkg::OP_SET_COMPARE;
         pick = $urandom_range(99);
         if (pick < 50)
            tgt = now_if_read() + TIME_W'($urandom_range(12));
         else if (pick < 60)
            tgt = now_if_read() - TIME_W'($urandom_range(40, 1));
         else if (pick < 70)
            tgt = now_if_read() + TIME_W'($urandom_range(32'h200_0000, 13));
         else if (pick < 78)
            tgt = TIME_IDLE;
      end
      send_word(op, tgt, 1'b0, '0);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [TIME_W-1:0] tgt;
      timebase.down     = '0;
      timebase.reload   = CNT_MAX - 1'b1;
      timebase.wrapped  = 1'b0;
      timebase.snap     = CNT_MAX;
      timebase.total    = '0;
      timebase.deadline = TIME_IDLE;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         tgt = plan[i].rel ? now_if_read() + plan[i].tgt : plan[i].tgt;
         send_word(plan[i].op, tgt, plan[i].typed, {plan[i].fire, plan[i].now});
      end
      drain_results();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         steady = (n >= 400 && n < 650);
         if (n == 700)
            drain_results();
         random_word();
      end
      steady = 1'b0;

      drain_results();
      repeat (8) @(posedge clock);   // anything extra after the last word
      if (due_results.size() != 0)
         flag_mismatch($sformatf("%0d result words never arrived", due_results.size()));
      if (mismatches == 0)
         $display("extended_timebase_with_compare_test: clean");
      else
         $display("extended_timebase_with_compare_test: errors");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: random back-pressure, off during the steady stretch
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Result check: field by field against the oldest pending expectation.
   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            flag_mismatch($sformatf("unexpected word now=%h fire=%b",
                                    rsp_tdata[TIME_W-1:0], rsp_tdata[TIME_W]));
         end else begin
            want = due_results.pop_front();
            if (rsp_tdata[TIME_W-1:0] !== want.now)
               flag_mismatch($sformatf("now_ticks exp %h got %h",
                                       want.now, rsp_tdata[TIME_W-1:0]));
            if (rsp_tdata[TIME_W] !== want.fire)
               flag_mismatch($sformatf("event_fire exp %b got %b",
                                       want.fire, rsp_tdata[TIME_W]));
         end
      end
   end

   // Watchdog: nothing moving on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("extended_timebase_with_compare_test: errors");
         $finish;
      end
   end

endmodule
